@@ rtl/ngwc_pkg.sv @@
// Package for the n-gram window counter: sizes, payload structs, controller
// states, command and status groups, and the bucket hash.
// Depends on nothing; every other file of the block imports it.
package ngwc_pkg;

    // Block sizing.
    localparam int ORDER      = 3;
    localparam int WORD_BITS  = 16;
    localparam int CAPACITY   = 1024;

    localparam int HIST_LEN      = ORDER - 1;
    localparam int HIST_VEC_BITS = (HIST_LEN > 0) ? HIST_LEN * WORD_BITS : 1;
    localparam int KEY_BITS      = ORDER * WORD_BITS;
    localparam int SLOT_BITS     = $clog2(CAPACITY);
    localparam int USED_BITS     = SLOT_BITS + 1;
    // The bucket index has twice as many entries as the table can hold,
    // so a probe sequence always ends at an empty bucket.
    localparam int IDX_BITS      = SLOT_BITS + 1;
    localparam int IDX_DEPTH     = 1 << IDX_BITS;

    localparam int IN_WORD_BITS  = 16;
    localparam int OUT_SLOT_BITS = 10;
    localparam int COUNT_BITS    = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [WORD_BITS-1:0]  PAD_WORD  = WORD_BITS'(1);

    localparam int HASH_CHUNKS   = (KEY_BITS + IDX_BITS - 1) / IDX_BITS;
    localparam int HASH_PAD_BITS = HASH_CHUNKS * IDX_BITS;

    // Input and result payloads.
    typedef struct packed {
        logic [IN_WORD_BITS-1:0] word;
        logic                    sentence_start;
    } ngwc_item_t;

    typedef struct packed {
        logic [OUT_SLOT_BITS-1:0] slot;
        logic [COUNT_BITS-1:0]    count;
        logic                     new_entry;
        logic                     table_full;
    } ngwc_result_t;

    // One bucket of the hash index: an occupied flag and the table slot.
    typedef struct packed {
        logic                 used;
        logic [SLOT_BITS-1:0] slot;
    } ngwc_bucket_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IDX_RD,
        ST_IDX_CHK,
        ST_KEY_RD,
        ST_KEY_CHK,
        ST_HIT,
        ST_MISS
    } ngwc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic take_slot;
        logic next_probe;
        logic do_hit;
        logic do_miss;
    } ngwc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic idx_used;
        logic key_match;
        logic out_free;
    } ngwc_status_t;

    // History made of pad words only, oldest word in the high bits.
    function automatic logic [HIST_VEC_BITS-1:0] pad_history();
        logic [HIST_VEC_BITS-1:0] h;
        h = '0;
        for (int i = 0; i < HIST_LEN; i++) begin
            h[i*WORD_BITS +: WORD_BITS] = PAD_WORD;
        end
        return h;
    endfunction

    // Fold the key into a bucket index, each chunk rotated by its position.
    function automatic logic [IDX_BITS-1:0] key_hash(input logic [KEY_BITS-1:0] key);
        logic [HASH_PAD_BITS-1:0] padded;
        logic [IDX_BITS-1:0]      acc;
        logic [IDX_BITS-1:0]      chunk;
        padded = HASH_PAD_BITS'(key);
        acc    = '0;
        for (int i = 0; i < HASH_CHUNKS; i++) begin
            chunk = padded[i*IDX_BITS +: IDX_BITS];
            acc   = acc ^ ((chunk << (i % IDX_BITS))
                         | (chunk >> ((IDX_BITS - (i % IDX_BITS)) % IDX_BITS)));
        end
        return acc;
    endfunction

endpackage

@@ rtl/ngwc_ctrl.sv @@
// Controller of the n-gram window counter: the sequencer that clears the
// hash index, takes items, walks the probe chain and retires each result.
// Depends on ngwc_pkg.
module ngwc_ctrl
    import ngwc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ngwc_status_t status,
    output ngwc_cmd_t    cmd
);

    ngwc_state_t state_reg;
    ngwc_state_t state_next;

    // State register; reset starts the index clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_IDX_RD;
                end
            end
            ST_IDX_RD: begin
                state_next = ST_IDX_CHK;
            end
            ST_IDX_CHK: begin
                // An empty bucket ends the chain: the key is not in the table.
                if (status.idx_used) begin
                    cmd.take_slot = 1'b1;
                    state_next    = ST_KEY_RD;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_KEY_RD: begin
                state_next = ST_KEY_CHK;
            end
            ST_KEY_CHK: begin
                if (status.key_match) begin
                    state_next = ST_HIT;
                end else begin
                    cmd.next_probe = 1'b1;
                    state_next     = ST_IDX_RD;
                end
            end
            ST_HIT: begin
                if (status.out_free) begin
                    cmd.do_hit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (status.out_free) begin
                    cmd.do_miss = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ngwc_datapath.sv @@
// Datapath of the n-gram window counter: word history, key register, hash
// index, key and count memories, fill count and the result register.
// Depends on ngwc_pkg; driven by commands from ngwc_ctrl.
module ngwc_datapath
    import ngwc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ngwc_item_t   s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output ngwc_result_t m_data,
    input  ngwc_cmd_t    cmd,
    output ngwc_status_t status
);

    // Memories.
    ngwc_bucket_t          idx_mem [IDX_DEPTH];
    logic [KEY_BITS-1:0]   key_mem [CAPACITY];
    logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];

    logic [HIST_VEC_BITS-1:0] hist_reg;
    logic [HIST_VEC_BITS-1:0] hist_next;
    logic [HIST_VEC_BITS-1:0] hist_eff;
    logic [WORD_BITS-1:0]     word_in;
    logic [KEY_BITS-1:0]      key_in;
    logic [KEY_BITS-1:0]      key_reg;
    logic [IDX_BITS-1:0]      probe_reg;
    logic [IDX_BITS-1:0]      clr_reg;
    logic [SLOT_BITS-1:0]     slot_reg;
    logic [USED_BITS-1:0]     used_reg;
    ngwc_bucket_t             idx_data_reg;
    logic [KEY_BITS-1:0]      key_data_reg;
    logic [COUNT_BITS-1:0]    cnt_data_reg;
    logic [COUNT_BITS-1:0]    cnt_hit;
    logic                     has_room;
    logic [SLOT_BITS-1:0]     new_slot;
    logic                     m_valid_reg;
    ngwc_result_t             m_data_reg;

    // Key of the incoming word: history (pad words at a sentence start)
    // followed by the current word.
    assign word_in  = WORD_BITS'(s_data.word);
    assign hist_eff = s_data.sentence_start ? pad_history() : hist_reg;

    generate
        if (HIST_LEN == 0) begin : g_no_hist
            assign key_in    = word_in;
            assign hist_next = hist_eff;
        end else if (HIST_LEN == 1) begin : g_one_hist
            assign key_in    = {hist_eff, word_in};
            assign hist_next = word_in;
        end else begin : g_hist
            assign key_in    = {hist_eff, word_in};
            assign hist_next = {hist_eff[HIST_VEC_BITS-WORD_BITS-1:0], word_in};
        end
    endgenerate

    // History advances with every accepted word, dropped or not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= pad_history();
        end else if (cmd.load_item) begin
            hist_reg <= hist_next;
        end
    end

    // Key register, probe pointer and the slot under comparison.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            key_reg   <= key_in;
            probe_reg <= key_hash(key_in);
        end else if (cmd.next_probe) begin
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.take_slot) begin
            slot_reg <= idx_data_reg.slot;
        end
    end

    // Clearing pass over the hash index and the fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            used_reg <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.do_miss && has_room) begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    assign has_room = (used_reg < USED_BITS'(CAPACITY));
    assign new_slot = used_reg[SLOT_BITS-1:0];

    // Hash index: cleared after reset, filled on insertion, read every cycle.
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            idx_mem[clr_reg] <= '0;
        end else if (cmd.do_miss && has_room) begin
            idx_mem[probe_reg] <= '{used: 1'b1, slot: new_slot};
        end
        idx_data_reg <= idx_mem[probe_reg];
    end

    // Key memory: written on insertion, read at the slot under comparison.
    always_ff @(posedge aclk) begin
        if (cmd.do_miss && has_room) begin
            key_mem[new_slot] <= key_reg;
        end
        key_data_reg <= key_mem[slot_reg];
    end

    // Count memory: one write port shared by hit and insertion.
    always_ff @(posedge aclk) begin
        if (cmd.do_hit) begin
            cnt_mem[slot_reg] <= cnt_hit;
        end else if (cmd.do_miss && has_room) begin
            cnt_mem[new_slot] <= COUNT_BITS'(1);
        end
        cnt_data_reg <= cnt_mem[slot_reg];
    end

    // Saturating increment of the stored count.
    assign cnt_hit = (cnt_data_reg == COUNT_MAX) ? cnt_data_reg : cnt_data_reg + 1'b1;

    // Result register; it is loaded only when empty or being emptied.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_hit || cmd.do_miss) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_hit) begin
            m_data_reg.slot       <= OUT_SLOT_BITS'(slot_reg);
            m_data_reg.count      <= cnt_hit;
            m_data_reg.new_entry  <= 1'b0;
            m_data_reg.table_full <= 1'b0;
        end else if (cmd.do_miss) begin
            if (has_room) begin
                m_data_reg.slot       <= OUT_SLOT_BITS'(new_slot);
                m_data_reg.count      <= COUNT_BITS'(1);
                m_data_reg.new_entry  <= 1'b1;
                m_data_reg.table_full <= 1'b0;
            end else begin
                m_data_reg.slot       <= '0;
                m_data_reg.count      <= '0;
                m_data_reg.new_entry  <= 1'b0;
                m_data_reg.table_full <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status for the controller.
    assign status.clear_done = (clr_reg == '1);
    assign status.idx_used   = idx_data_reg.used;
    assign status.key_match  = (key_data_reg == key_reg);
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

@@ rtl/ngram_window_counter.sv @@
// Top level of the n-gram window counter: joins the controller and the
// datapath. Depends on ngwc_pkg, ngwc_ctrl and ngwc_datapath.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    ngwc_item_t   (word, sentence_start)
//   m_        out        m_valid/m_ready    ngwc_result_t (slot, count, new_entry,
//                                                          table_full)
//
// One item is in flight at a time. A lookup reads a bucket of the hash index,
// then, if the bucket is used, the key at its slot, each read registered; a
// key mismatch moves on to the next bucket and repeats both reads.
// After reset the block clears every bucket of the hash index before s_ready rises.
// The result register frees the input side: a new item is taken while the
// previous result still waits on m_ready; the result stage stalls only when
// a second result is ready before the first is transferred.
module ngram_window_counter
    import ngwc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ngwc_item_t   s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output ngwc_result_t m_data
);

    ngwc_cmd_t    cmd;
    ngwc_status_t status;

    ngwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ngwc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

@@ bench/tb_ngram_window_counter.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ngram_window_counter: streams word items through
// the s_ channel, predicts every m_ result in the bench and compares fields.
// Depends on ngwc_pkg and the ngram_window_counter RTL.
module tb_ngram_window_counter;
    import ngwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // Small vocabulary so that random sentences repeat n-grams and hit.
    localparam logic [IN_WORD_BITS-1:0] VOCAB [0:7] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h0003,
        16'h0007, 16'h00FF, 16'h8000, 16'hFFFF
    };

    // Directed opening sequence: extreme words, pad-like words, hits and restarts.
    localparam int DIR_ITEMS = 20;
    localparam logic [IN_WORD_BITS-1:0] DIR_WORDS [0:DIR_ITEMS-1] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0001, 16'h0001, 16'h0001,
        16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hAAAA,
        16'h0000, 16'h0000
    };
    localparam logic DIR_STARTS [0:DIR_ITEMS-1] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b0
    };

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    ngwc_item_t   s_data;
    logic         m_valid;
    logic         m_ready;
    ngwc_result_t m_data;

    // Predictor state: history window and the n-gram table contents.
    logic [WORD_BITS-1:0]  hist_words [ORDER];
    logic [KEY_BITS-1:0]   key_table [CAPACITY];
    logic [COUNT_BITS-1:0] count_table [CAPACITY];
    int                    filled_slots;

    ngwc_result_t expected_results [$];
    ngwc_result_t want;
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           tx_gaps_on;
    bit           rx_stalls_on;

    ngram_window_counter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Word choice for random text: mostly the small vocabulary.
    function automatic logic [IN_WORD_BITS-1:0] text_word();
        if ($urandom_range(0, 99) < 75) begin
            return VOCAB[$urandom_range(0, 7)];
        end
        return IN_WORD_BITS'($urandom());
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < ORDER; i++) begin
            hist_words[i] = PAD_WORD;
        end
        filled_slots = 0;
    endfunction

    // Lookup-or-insert on the bench's copy of the table; returns the result
    // the block must produce and advances the history window.
    function automatic ngwc_result_t predict_ngram(input ngwc_item_t item);
        logic [WORD_BITS-1:0] w;
        logic [KEY_BITS-1:0]  key;
        ngwc_result_t         r;
        int                   hit_slot;
        w = WORD_BITS'(item.word);
        if (item.sentence_start) begin
            for (int i = 0; i < ORDER; i++) begin
                hist_words[i] = PAD_WORD;
            end
        end
        key = '0;
        for (int i = 0; i < HIST_LEN; i++) begin
            key = (key << WORD_BITS) | KEY_BITS'(hist_words[i]);
        end
        key = (key << WORD_BITS) | KEY_BITS'(w);

        hit_slot = -1;
        for (int s = 0; s < filled_slots; s++) begin
            if (key_table[s] == key) begin
                hit_slot = s;
                break;
            end
        end

        r = '0;
        if (hit_slot >= 0) begin
            // Counts saturate at all ones.
            if (count_table[hit_slot] != COUNT_MAX) begin
                count_table[hit_slot] = count_table[hit_slot] + 1;
            end
            r.slot  = OUT_SLOT_BITS'(hit_slot);
            r.count = count_table[hit_slot];
        end else if (filled_slots < CAPACITY) begin
            key_table[filled_slots]   = key;
            count_table[filled_slots] = 1;
            r.slot      = OUT_SLOT_BITS'(filled_slots);
            r.count     = 1;
            r.new_entry = 1'b1;
            filled_slots++;
        end else begin
            // Table full: the n-gram is dropped, the history still moves on.
            r.table_full = 1'b1;
        end

        for (int i = 0; i + 1 < HIST_LEN; i++) begin
            hist_words[i] = hist_words[i+1];
        end
        if (HIST_LEN > 0) begin
            hist_words[HIST_LEN-1] = w;
        end
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record its result.
    task automatic send_item(input logic [IN_WORD_BITS-1:0] w, input logic start);
        int         gap;
        ngwc_item_t item;
        gap = tx_gaps_on ? pick_gap() : 0;
        item.word           = w;
        item.sentence_start = start;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_ngram(item));
    endtask

    // Stop offering items and wait for every outstanding result.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        for (int i = 0; i < DIR_ITEMS; i++) begin
            send_item(DIR_WORDS[i], DIR_STARTS[i]);
        end
    endtask

    // Sentences of random length; a few lack the start flag or restart midway.
    task automatic test_random_text(input int n_items);
        int  sent;
        int  len;
        logic start;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && sent < n_items; i++) begin
                if (i == 0) begin
                    start = ($urandom_range(0, 9) != 0);
                end else begin
                    start = ($urandom_range(0, 29) == 0);
                end
                send_item(text_word(), start);
                sent++;
            end
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_text(40);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // The sender holds off until every result is back, then resumes.
    task automatic test_pause_for_results();
        test_random_text(25);
        wait_for_results();
        test_random_text(10);
    endtask

    // Result side pacing.
    initial begin : rx_pacing
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (rx_stalls_on) begin
                    hold = pick_gap();
                end
            end
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: slot %0d count %0d",
                       m_data.slot, m_data.count);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, m_data.slot);
                    mismatches++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, m_data.count);
                    mismatches++;
                end
                if (m_data.new_entry !== want.new_entry) begin
                    $error("new_entry: expected %0b, actual %0b",
                           want.new_entry, m_data.new_entry);
                    mismatches++;
                end
                if (m_data.table_full !== want.table_full) begin
                    $error("table_full: expected %0b, actual %0b",
                           want.table_full, m_data.table_full);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        reset_predictor();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_text(355);
        test_back_to_back();
        test_pause_for_results();

        wait_for_results();
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
